// ===== hdl/scl_pkg.sv =====
// Shared types, character codes and classification functions for the shell command lexer.
// No dependencies; every other file of the block refers to this package by scoped names.
`timescale 1ns / 1ps

package scl_pkg;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [2:0] {
      MODE_START = 3'd0,
      MODE_WORD  = 3'd1,
      MODE_OP1   = 3'd2,
      MODE_SKIP  = 3'd3,
      MODE_STOP  = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      KIND_CHAR      = 3'd0,
      KIND_TOKEN_END = 3'd1,
      KIND_LINE_END  = 3'd2,
      KIND_BAD       = 3'd3,
      KIND_INPUT_END = 3'd4
   } kind_type;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_PIPE  = 8'h7C;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] chr;
   } result_type;

   // one queue entry: one or two results caused by a single input transaction
   typedef struct packed {
      logic       two;
      result_type r0;
      result_type r1;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic       emit;
      result_type res;
      mode_type   mode;
   } bt_type;

   function automatic logic is_operator(input logic [7:0] c);
      return c == CH_PIPE || c == CH_AMP || c == CH_LPAR || c == CH_GT ||
             c == CH_LT || c == CH_SEMI || c == CH_RPAR;
   endfunction

   function automatic logic is_word_char(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
             (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER || c == CH_DOLLAR ||
             c == CH_SLASH || c == CH_DOT;
   endfunction

   function automatic logic is_separator(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_NL;
   endfunction

endpackage

// ===== hdl/scl_front.sv =====
// Front end: accepts characters, runs the lexer state and classifies each transaction
// into at most one queue entry of one or two results. Depends on scl_pkg.
`timescale 1ns / 1ps

module scl_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 req_tlast,
   input  scl_pkg::q_status_type q_status,
   output logic                 push,
   output scl_pkg::entry_type   push_entry
);

   scl_pkg::mode_type   mode_ff, mode_in;
   logic [7:0]          first_op_ff, first_op_in;
   logic                accept;
   logic                a_v, b_v;
   scl_pkg::result_type a_res, b_res;
   scl_pkg::bt_type     bt;

   function automatic scl_pkg::bt_type between(input logic [7:0] c);
      scl_pkg::bt_type r;
      r.emit     = 1'b1;
      r.res.kind = scl_pkg::KIND_CHAR;
      r.res.chr  = c;
      r.mode     = scl_pkg::MODE_START;
      if (c == scl_pkg::CH_SPACE || c == scl_pkg::CH_TAB) begin
         r.emit = 1'b0;
         r.res.chr = 8'h00;
      end else if (c == scl_pkg::CH_NL) begin
         r.res.kind = scl_pkg::KIND_LINE_END;
         r.res.chr  = 8'h00;
      end else if (scl_pkg::is_operator(c)) begin
         r.mode = scl_pkg::MODE_OP1;
      end else if (scl_pkg::is_word_char(c)) begin
         r.mode = scl_pkg::MODE_WORD;
      end else begin
         r.res.kind = scl_pkg::KIND_BAD;
         r.mode     = scl_pkg::MODE_SKIP;
      end
      return r;
   endfunction

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      bt          = between(req_tdata);
      a_v         = 1'b0;
      b_v         = 1'b0;
      a_res       = '{kind: scl_pkg::KIND_CHAR, chr: 8'h00};
      b_res       = '{kind: scl_pkg::KIND_CHAR, chr: 8'h00};
      mode_in     = mode_ff;
      case (mode_ff)
         scl_pkg::MODE_STOP: begin
         end
         scl_pkg::MODE_WORD, scl_pkg::MODE_OP1: begin
            a_v = 1'b1;
            if (req_tlast) begin
               a_res.kind = scl_pkg::KIND_TOKEN_END;
               b_v        = 1'b1;
               b_res.kind = scl_pkg::KIND_INPUT_END;
               mode_in    = scl_pkg::MODE_STOP;
            end else if (mode_ff == scl_pkg::MODE_WORD &&
                         scl_pkg::is_word_char(req_tdata)) begin
               a_res.chr = req_tdata;
            end else if (mode_ff == scl_pkg::MODE_WORD &&
                         !scl_pkg::is_operator(req_tdata) &&
                         !scl_pkg::is_separator(req_tdata)) begin
               a_res.kind = scl_pkg::KIND_BAD;
               a_res.chr  = req_tdata;
               mode_in    = scl_pkg::MODE_SKIP;
            end else if (mode_ff == scl_pkg::MODE_OP1 && req_tdata == first_op_ff &&
                         (req_tdata == scl_pkg::CH_PIPE || req_tdata == scl_pkg::CH_AMP ||
                          req_tdata == scl_pkg::CH_GT)) begin
               a_res.chr  = req_tdata;
               b_v        = 1'b1;
               b_res.kind = scl_pkg::KIND_TOKEN_END;
               mode_in    = scl_pkg::MODE_START;
            end else begin
               a_res.kind = scl_pkg::KIND_TOKEN_END;
               b_v        = bt.emit;
               b_res      = bt.res;
               mode_in    = bt.mode;
            end
         end
         scl_pkg::MODE_SKIP: begin
            if (req_tlast) begin
               a_v        = 1'b1;
               a_res.kind = scl_pkg::KIND_INPUT_END;
               mode_in    = scl_pkg::MODE_STOP;
            end else if (req_tdata == scl_pkg::CH_NL) begin
               a_v        = 1'b1;
               a_res.kind = scl_pkg::KIND_LINE_END;
               mode_in    = scl_pkg::MODE_START;
            end
         end
         default: begin
            if (req_tlast) begin
               a_v        = 1'b1;
               a_res.kind = scl_pkg::KIND_INPUT_END;
               mode_in    = scl_pkg::MODE_STOP;
            end else begin
               a_v     = bt.emit;
               a_res   = bt.res;
               mode_in = bt.mode;
            end
         end
      endcase
      // only a fresh operator leads into MODE_OP1
      first_op_in = (mode_in == scl_pkg::MODE_OP1) ? req_tdata : first_op_ff;
   end

   assign push          = accept && a_v;
   assign push_entry.two = b_v;
   assign push_entry.r0  = a_res;
   assign push_entry.r1  = b_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= scl_pkg::MODE_START;
         first_op_ff <= 8'h00;
      end else if (accept) begin
         mode_ff     <= mode_in;
         first_op_ff <= first_op_in;
      end
   end

endmodule

// ===== hdl/scl_queue.sv =====
// Short entry queue between the classifier front end and the result back end.
// Depends on scl_pkg for the entry type and depth.
`timescale 1ns / 1ps

module scl_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  scl_pkg::entry_type    push_entry,
   input  logic                  pop,
   output scl_pkg::entry_type    head,
   output scl_pkg::q_status_type status
);

   scl_pkg::entry_type              slots_ff [scl_pkg::QDEPTH];
   logic [scl_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [scl_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [scl_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign status.full  = count_ff == scl_pkg::QCNT_W'(scl_pkg::QDEPTH);
   assign status.empty = count_ff == '0;
   assign head         = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/scl_back.sv =====
// Back end: drains queue entries and drives the result stream through an output register,
// one result per cycle while the receiver is ready. Depends on scl_pkg.
`timescale 1ns / 1ps

module scl_back (
   input  logic                  clock,
   input  logic                  reset,
   input  scl_pkg::entry_type    head,
   input  scl_pkg::q_status_type q_status,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic [2:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   logic                rsp_valid_ff, rsp_valid_in;
   scl_pkg::result_type rsp_res_ff, rsp_res_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                phase_ff, phase_in;
   logic                load;

   assign load = !rsp_valid_ff || rsp_tready;

   always_comb begin
      pop          = 1'b0;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = !q_status.empty;
         if (!q_status.empty) begin
            if (head.two && !phase_ff) begin
               rsp_res_in  = head.r0;
               rsp_last_in = 1'b0;
               phase_in    = 1'b1;
            end else begin
               rsp_res_in  = phase_ff ? head.r1 : head.r0;
               rsp_last_in = 1'b1;
               phase_in    = 1'b0;
               pop         = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff  <= rsp_res_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_res_ff.chr;
   assign rsp_tuser  = rsp_res_ff.kind;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hdl/shell_command_lexer_core.sv =====
// Shell command lexer top level: front end, entry queue and result back end.
// Depends on scl_pkg, scl_front, scl_queue and scl_back.
`timescale 1ns / 1ps

// Takes one character per cycle while the queue is not full and streams out token
// characters, token end, line end, bad-character and input-end marks. A character
// causing two results (a word ended by an operator or newline, a doubled operator, end of
// input inside a token) occupies the output register for both, and the four-entry queue
// between the lexer state machine and the output register absorbs those bursts. The first
// result of an accepted character is registered in the queue, then in the output register,
// before it is presented. After the end-of-input mark the block ignores all input until
// reset.

module shell_command_lexer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] ch
   input  logic       req_tlast,   // end_of_input
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic [2:0] rsp_tuser,   // [2:0] kind
   output logic       rsp_tlast    // last result of the transaction
);

   logic                  push;
   logic                  pop;
   scl_pkg::entry_type    push_entry;
   scl_pkg::entry_type    head;
   scl_pkg::q_status_type q_status;

   scl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   scl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   scl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hdl/scl_checker.sv =====
// Port-level checks for the shell command lexer, bound to shell_command_lexer_core.
// Depends on scl_pkg for the result kind codes.
`timescale 1ns / 1ps

module scl_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [2:0] rsp_tuser,
   input logic       rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_char_only_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != scl_pkg::KIND_CHAR && rsp_tuser != scl_pkg::KIND_BAD
      |-> rsp_tdata == 8'h00)
      else $error("nonzero character on a mark");

   a_input_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == scl_pkg::KIND_INPUT_END |-> rsp_tlast)
      else $error("input end is not the final result");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind shell_command_lexer_core scl_checker u_scl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== bench/tb_shell_command_lexer_core.sv =====
// Self-checking testbench for shell_command_lexer_core: random and directed character streams,
// a scoreboard class that predicts each token result, and random idling on both streams.
// Depends on scl_pkg (kind and mode enums, character codes) and the core RTL.
`timescale 1ns / 1ps

class lex_scoreboard;
   typedef struct packed {
      scl_pkg::kind_type kind;
      logic [7:0]        chr;
      logic              last;
   } lex_result_type;

   lex_result_type    pending[$];
   scl_pkg::mode_type mode;
   logic [7:0]        pend_op;
   int                errors;
   int                checked;
   int                kind_seen[5];

   function new();
      mode    = scl_pkg::MODE_START;
      pend_op = '0;
      errors  = 0;
      checked = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
   endfunction

   function bit is_op(logic [7:0] c);
      return c inside {scl_pkg::CH_PIPE, scl_pkg::CH_AMP, scl_pkg::CH_SEMI, scl_pkg::CH_LT,
                       scl_pkg::CH_GT, scl_pkg::CH_LPAR, scl_pkg::CH_RPAR};
   endfunction

   function bit is_word(logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                       scl_pkg::CH_UNDER, scl_pkg::CH_DOLLAR, scl_pkg::CH_SLASH,
                       scl_pkg::CH_DOT};
   endfunction

   function bit is_blank(logic [7:0] c);
      return c inside {scl_pkg::CH_SPACE, scl_pkg::CH_TAB, scl_pkg::CH_NL};
   endfunction

   function bit is_allowed(logic [7:0] c);
      return is_op(c) || is_word(c) || is_blank(c);
   endfunction

   function void push(scl_pkg::kind_type k, logic [7:0] c);
      lex_result_type r;
      r.kind = k;
      r.chr  = c;
      r.last = 1'b0;
      pending.push_back(r);
   endfunction

   function void lex_between(logic [7:0] c);
      if (c == scl_pkg::CH_SPACE || c == scl_pkg::CH_TAB) begin
         mode = scl_pkg::MODE_START;
      end else if (c == scl_pkg::CH_NL) begin
         push(scl_pkg::KIND_LINE_END, 8'h00);
         mode = scl_pkg::MODE_START;
      end else if (is_op(c)) begin
         push(scl_pkg::KIND_CHAR, c);
         pend_op = c;
         mode = scl_pkg::MODE_OP1;
      end else if (is_word(c)) begin
         push(scl_pkg::KIND_CHAR, c);
         mode = scl_pkg::MODE_WORD;
      end else begin
         push(scl_pkg::KIND_BAD, c);
         mode = scl_pkg::MODE_SKIP;
      end
   endfunction

   // predict the results of one accepted input transaction
   function void note_input(logic [7:0] c, logic eoi);
      int n0;
      n0 = pending.size();
      case (mode)
         scl_pkg::MODE_STOP: ;
         scl_pkg::MODE_WORD: begin
            if (eoi) begin
               push(scl_pkg::KIND_TOKEN_END, 8'h00);
               push(scl_pkg::KIND_INPUT_END, 8'h00);
               mode = scl_pkg::MODE_STOP;
            end else if (is_word(c)) begin
               push(scl_pkg::KIND_CHAR, c);
            end else if (is_op(c) || is_blank(c)) begin
               push(scl_pkg::KIND_TOKEN_END, 8'h00);
               lex_between(c);
            end else begin
               push(scl_pkg::KIND_BAD, c);
               mode = scl_pkg::MODE_SKIP;
            end
         end
         scl_pkg::MODE_OP1: begin
            if (eoi) begin
               push(scl_pkg::KIND_TOKEN_END, 8'h00);
               push(scl_pkg::KIND_INPUT_END, 8'h00);
               mode = scl_pkg::MODE_STOP;
            end else if (c == pend_op &&
                         c inside {scl_pkg::CH_PIPE, scl_pkg::CH_AMP, scl_pkg::CH_GT}) begin
               push(scl_pkg::KIND_CHAR, c);
               push(scl_pkg::KIND_TOKEN_END, 8'h00);
               mode = scl_pkg::MODE_START;
            end else begin
               push(scl_pkg::KIND_TOKEN_END, 8'h00);
               lex_between(c);
            end
         end
         scl_pkg::MODE_SKIP: begin
            if (eoi) begin
               push(scl_pkg::KIND_INPUT_END, 8'h00);
               mode = scl_pkg::MODE_STOP;
            end else if (c == scl_pkg::CH_NL) begin
               push(scl_pkg::KIND_LINE_END, 8'h00);
               mode = scl_pkg::MODE_START;
            end
         end
         default: begin
            if (eoi) begin
               push(scl_pkg::KIND_INPUT_END, 8'h00);
               mode = scl_pkg::MODE_STOP;
            end else begin
               lex_between(c);
            end
         end
      endcase
      if (pending.size() > n0) pending[pending.size() - 1].last = 1'b1;
   endfunction

   function int outstanding();
      return pending.size();
   endfunction

   function void check_result(logic [2:0] k, logic [7:0] c, logic l);
      lex_result_type want;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result: expected none actual kind=%0d char=%02h last=%0b",
                  $time, k, c, l);
         errors++;
         return;
      end
      want = pending.pop_front();
      checked++;
      if (k !== want.kind) begin
         $display("%0t: kind mismatch: expected %0d actual %0d", $time, want.kind, k);
         errors++;
      end
      if (c !== want.chr) begin
         $display("%0t: char mismatch: expected %02h actual %02h", $time, want.chr, c);
         errors++;
      end
      if (l !== want.last) begin
         $display("%0t: last mismatch: expected %0b actual %0b", $time, want.last, l);
         errors++;
      end
      if (want.kind <= scl_pkg::KIND_INPUT_END) kind_seen[want.kind]++;
   endfunction
endclass

module tb_shell_command_lexer_core;

   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_LEN    = 60;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic       rsp_tlast;

   lex_scoreboard sb;
   int    send_idle_pct = 0;
   int    recv_idle_pct = 0;
   int    items_sent    = 0;
   int    cycles        = 0;
   int    hold_requests = 0;
   int    hold_served   = 0;
   int    hold_left     = 0;
   string word_set      = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789_$/.";
   string op_set        = "|&;<>()";

   shell_command_lexer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side: check every transaction, random stall, long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_LEN;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_char(input logic [7:0] c, input logic eoi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= eoi;
      do @(posedge clock); while (!req_tready);
      sb.note_input(c, eoi);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
   endtask

   function automatic logic [7:0] rand_char();
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] bad_char();
      logic [7:0] c;
      do c = rand_char(); while (sb.is_allowed(c));
      return c;
   endfunction

   function automatic logic [7:0] blank_char();
      return $urandom_range(1) ? scl_pkg::CH_SPACE : scl_pkg::CH_TAB;
   endfunction

   task automatic send_token();
      logic [7:0] op;
      int         len;
      if ($urandom_range(99) < 60) begin
         len = $urandom_range(1, 8);
         repeat (len) send_char(word_set[$urandom_range(word_set.len() - 1)], 1'b0);
      end else begin
         op = op_set[$urandom_range(op_set.len() - 1)];
         send_char(op, 1'b0);
         if ($urandom_range(99) < 35) send_char(op, 1'b0);
         else if ($urandom_range(99) < 25)
            send_char(op_set[$urandom_range(op_set.len() - 1)], 1'b0);
      end
   endtask

   // one command line: mostly well-formed, some with a bad character, some pure noise
   task automatic send_line();
      int shape;
      int ntok;
      shape = $urandom_range(99);
      ntok  = $urandom_range(1, 6);
      if (shape < 80) begin
         for (int t = 0; t < ntok; t++) begin
            repeat ($urandom_range(0, 2)) send_char(blank_char(), 1'b0);
            send_token();
         end
         repeat ($urandom_range(0, 1)) send_char(blank_char(), 1'b0);
         if ($urandom_range(99) < 90) send_char(scl_pkg::CH_NL, 1'b0);
      end else if (shape < 92) begin
         repeat ($urandom_range(0, 3)) begin
            send_token();
            send_char(blank_char(), 1'b0);
         end
         if ($urandom_range(1)) send_token();
         send_char(bad_char(), 1'b0);
         repeat ($urandom_range(0, 6)) send_char(rand_char(), 1'b0);
         send_char(scl_pkg::CH_NL, 1'b0);
      end else begin
         repeat ($urandom_range(1, 10)) send_char(rand_char(), 1'b0);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() > 0);
   endtask

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // word extremes, word then operator, doubled and undoubled operators,
      // word then newline, bad char between tokens and inside a word
      send_idle_pct = 20;
      recv_idle_pct = 30;
      send_text("Az09_$/.||&&>><<( ;)\tx\n");
      send_char(8'h00, 1'b0);
      send_char(scl_pkg::CH_NL, 1'b0);
      send_char("q", 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(scl_pkg::CH_NL, 1'b0);
      wait_drained();

      send_idle_pct = 37;
      recv_idle_pct = 56;
      while (items_sent < 650) send_line();
      wait_drained();

      send_idle_pct = 56;
      recv_idle_pct = 37;
      while (items_sent < 1300) send_line();
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests++;
      while (items_sent < 1900) send_line();

      // end of input from a random lexer state, then inputs after stop
      case ($urandom_range(3))
         0: send_text("ab");
         1: send_char(scl_pkg::CH_AMP, 1'b0);
         2: send_char(bad_char(), 1'b0);
         default: send_char(scl_pkg::CH_NL, 1'b0);
      endcase
      send_char(rand_char(), 1'b1);
      repeat (4) send_char(rand_char(), 1'($urandom_range(1)));
      wait_drained();
      repeat (12) @(posedge clock);

      $display("Fed %0d characters in three stall mixes with a long output hold-off;",
               items_sent);
      $display("checked %0d results: %0d chars, %0d token ends, %0d line ends,",
               sb.checked, sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2]);
      $display("%0d aborts, %0d input ends", sb.kind_seen[3], sb.kind_seen[4]);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== shell_command_lexer_core.f =====
hdl/scl_pkg.sv
hdl/scl_front.sv
hdl/scl_queue.sv
hdl/scl_back.sv
hdl/shell_command_lexer_core.sv
hdl/scl_checker.sv
bench/tb_shell_command_lexer_core.sv
